### rtl/fbc_pkg.sv
// ----------------------------------------------------------------------------
// fbc_pkg
// Shared types, constants and helpers for the frustum box culling block.
// ----------------------------------------------------------------------------
package fbc_pkg;

   // Plane count and the width in which coordinates and coefficients are read.
   localparam int PLANE_COUNT    = 6;
   localparam int COORD_WIDTH    = 32;

   // Fixed widths of the transaction fields.
   localparam int FIELD_W        = 32;
   localparam int CMD_W          = 2;
   localparam int SLOT_W         = 5;
   localparam int COEF_SEL_W     = 2;
   localparam int PLANE_SEL_W    = SLOT_W - COEF_SEL_W;
   localparam int COEF_PER_PLANE = 4;
   localparam int OUT_MASK_W     = 6;

   // Arithmetic widths. Above the field width the fields read as unsigned,
   // so one extra bit keeps them positive.
   localparam int USE_W   = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
   localparam int OP_W    = (COORD_WIDTH > FIELD_W) ? FIELD_W + 1 : COORD_WIDTH;
   localparam bit SIGN_EXT = (COORD_WIDTH <= FIELD_W);
   localparam int PROD_W  = 2 * OP_W;
   localparam int SUM_W   = 2 * OP_W + 3;
   localparam int D_SHIFT = 16;

   localparam logic [PLANE_COUNT-1:0] ALL_PLANES = {PLANE_COUNT{1'b1}};

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_BOX    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CORNER = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // Result kinds.
   localparam logic KIND_BOX    = 1'b0;
   localparam logic KIND_CORNER = 1'b1;

   // One transaction as it travels down the row of plane cells.
   typedef struct packed {
      logic [CMD_W-1:0]       command;
      logic [SLOT_W-1:0]      slot;
      logic [FIELD_W-1:0]     value;
      logic [FIELD_W-1:0]     lo_x;
      logic [FIELD_W-1:0]     lo_y;
      logic [FIELD_W-1:0]     lo_z;
      logic [FIELD_W-1:0]     hi_x;
      logic [FIELD_W-1:0]     hi_y;
      logic [FIELD_W-1:0]     hi_z;
      logic                   last;
      logic [PLANE_COUNT-1:0] near_mask;
      logic [PLANE_COUNT-1:0] far_mask;
   } item_type;

   // Reads a field as two's complement in its low COORD_WIDTH bits.
   function automatic logic signed [OP_W-1:0] to_operand(input logic [FIELD_W-1:0] v);
      logic signed [OP_W-1:0] r;
      for (int i = 0; i < OP_W; i++) begin
         if (i < USE_W) begin
            r[i] = v[i];
         end else begin
            r[i] = SIGN_EXT ? v[USE_W-1] : 1'b0;
         end
      end
      return r;
   endfunction

   function automatic logic positive(input logic signed [OP_W-1:0] v);
      return !v[OP_W-1] && (v != '0);
   endfunction

   // Fits a plane mask to the six-bit result field.
   function automatic logic [OUT_MASK_W-1:0] mask_to_out(input logic [PLANE_COUNT-1:0] m);
      logic [OUT_MASK_W-1:0] r;
      for (int i = 0; i < OUT_MASK_W; i++) begin
         r[i] = (i < PLANE_COUNT) ? m[i] : 1'b0;
      end
      return r;
   endfunction

endpackage

### rtl/fbc_cell.sv
// ----------------------------------------------------------------------------
// fbc_cell
// One plane of the frustum: holds its coefficients and tests each passing
// transaction in three stages (products, pair sums, final sum and sign).
// ----------------------------------------------------------------------------
module fbc_cell import fbc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [PLANE_SEL_W-1:0] plane_idx,
   input  logic                   up_valid,
   input  item_type               up_item,
   output logic                   up_ready,
   output logic                   dn_valid,
   output item_type               dn_item,
   input  logic                   dn_ready
);

   logic [FIELD_W-1:0]       coef_ff [COEF_PER_PLANE];
   logic [FIELD_W-1:0]       coef_in [COEF_PER_PLANE];

   logic                     s1_valid_ff, s1_valid_in;
   item_type                 s1_item_ff, s1_item_in;
   logic signed [PROD_W-1:0] near_prod_ff [3];
   logic signed [PROD_W-1:0] near_prod_in [3];
   logic signed [PROD_W-1:0] far_prod_ff [3];
   logic signed [PROD_W-1:0] far_prod_in [3];
   logic signed [SUM_W-1:0]  d_ff, d_in;

   logic                     s2_valid_ff, s2_valid_in;
   item_type                 s2_item_ff, s2_item_in;
   logic signed [SUM_W-1:0]  near_part_ff [2];
   logic signed [SUM_W-1:0]  near_part_in [2];
   logic signed [SUM_W-1:0]  far_part_ff [2];
   logic signed [SUM_W-1:0]  far_part_in [2];

   logic                     dn_valid_ff, dn_valid_in;
   item_type                 dn_item_ff, dn_item_in;

   logic                     s1_ready, s2_ready, dn_free;
   logic signed [OP_W-1:0]   ca, cb, cc, cd;
   logic                     pa, pb, pc;
   logic [FIELD_W-1:0]       nx, ny, nz, fx, fy, fz;
   logic signed [SUM_W-1:0]  near_sum, far_sum;
   logic                     near_out, far_out;

   always_comb begin
      dn_free  = !dn_valid_ff || dn_ready;
      s2_ready = !s2_valid_ff || dn_free;
      s1_ready = !s1_valid_ff || s2_ready;
      up_ready = s1_ready;

      ca = to_operand(coef_ff[0]);
      cb = to_operand(coef_ff[1]);
      cc = to_operand(coef_ff[2]);
      cd = to_operand(coef_ff[3]);
      pa = positive(ca);
      pb = positive(cb);
      pc = positive(cc);

      // Nearest corner takes the minimum where the coefficient is positive.
      nx = pa ? up_item.lo_x : up_item.hi_x;
      ny = pb ? up_item.lo_y : up_item.hi_y;
      nz = pc ? up_item.lo_z : up_item.hi_z;
      fx = pa ? up_item.hi_x : up_item.lo_x;
      fy = pb ? up_item.hi_y : up_item.lo_y;
      fz = pc ? up_item.hi_z : up_item.lo_z;

      coef_in = coef_ff;
      if (up_valid && s1_ready && (up_item.command == CMD_LOAD) &&
          (up_item.slot[SLOT_W-1:COEF_SEL_W] == plane_idx)) begin
         coef_in[up_item.slot[COEF_SEL_W-1:0]] = up_item.value;
      end

      // Stage one: six products.
      s1_valid_in  = s1_ready ? up_valid : s1_valid_ff;
      s1_item_in   = s1_item_ff;
      near_prod_in = near_prod_ff;
      far_prod_in  = far_prod_ff;
      d_in         = d_ff;
      if (s1_ready) begin
         s1_item_in      = up_item;
         near_prod_in[0] = PROD_W'(ca) * PROD_W'(to_operand(nx));
         near_prod_in[1] = PROD_W'(cb) * PROD_W'(to_operand(ny));
         near_prod_in[2] = PROD_W'(cc) * PROD_W'(to_operand(nz));
         far_prod_in[0]  = PROD_W'(ca) * PROD_W'(to_operand(fx));
         far_prod_in[1]  = PROD_W'(cb) * PROD_W'(to_operand(fy));
         far_prod_in[2]  = PROD_W'(cc) * PROD_W'(to_operand(fz));
         d_in            = SUM_W'(cd) <<< D_SHIFT;
      end

      // Stage two: pair sums.
      s2_valid_in  = s2_ready ? s1_valid_ff : s2_valid_ff;
      s2_item_in   = s2_item_ff;
      near_part_in = near_part_ff;
      far_part_in  = far_part_ff;
      if (s2_ready) begin
         s2_item_in      = s1_item_ff;
         near_part_in[0] = SUM_W'(near_prod_ff[0]) + SUM_W'(near_prod_ff[1]);
         near_part_in[1] = SUM_W'(near_prod_ff[2]) + d_ff;
         far_part_in[0]  = SUM_W'(far_prod_ff[0]) + SUM_W'(far_prod_ff[1]);
         far_part_in[1]  = SUM_W'(far_prod_ff[2]) + d_ff;
      end

      // Stage three: full sum, strict sign test, plane bit into the masks.
      near_sum = near_part_ff[0] + near_part_ff[1];
      far_sum  = far_part_ff[0] + far_part_ff[1];
      near_out = !near_sum[SUM_W-1] && (near_sum != '0);
      far_out  = !far_sum[SUM_W-1] && (far_sum != '0);

      dn_valid_in = dn_free ? s2_valid_ff : dn_valid_ff;
      dn_item_in  = dn_item_ff;
      if (dn_free) begin
         dn_item_in           = s2_item_ff;
         dn_item_in.near_mask = s2_item_ff.near_mask |
                                (PLANE_COUNT'(near_out) << plane_idx);
         dn_item_in.far_mask  = s2_item_ff.far_mask |
                                (PLANE_COUNT'(far_out) << plane_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         dn_valid_ff <= 1'b0;
         for (int k = 0; k < COEF_PER_PLANE; k++) begin
            coef_ff[k] <= '0;
         end
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         dn_valid_ff <= dn_valid_in;
         coef_ff     <= coef_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff   <= s1_item_in;
      near_prod_ff <= near_prod_in;
      far_prod_ff  <= far_prod_in;
      d_ff         <= d_in;
      s2_item_ff   <= s2_item_in;
      near_part_ff <= near_part_in;
      far_part_ff  <= far_part_in;
      dn_item_ff   <= dn_item_in;
   end

   assign dn_valid = dn_valid_ff;
   assign dn_item  = dn_item_ff;

endmodule

### rtl/fbc_retire.sv
// ----------------------------------------------------------------------------
// fbc_retire
// End of the plane row: folds corner codes into the AND/OR accumulators,
// forms results and holds them in the output register.
// ----------------------------------------------------------------------------
module fbc_retire import fbc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  item_type              item,
   output logic                  item_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_test_kind,
   output logic                  rsp_touches_frustum,
   output logic                  rsp_fully_inside,
   output logic [OUT_MASK_W-1:0] rsp_outside_mask
);

   logic [PLANE_COUNT-1:0] and_ff, and_in;
   logic [PLANE_COUNT-1:0] or_ff, or_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   kind_ff, kind_in;
   logic                   touches_ff, touches_in;
   logic                   fully_ff, fully_in;
   logic [OUT_MASK_W-1:0]  mask_ff, mask_in;

   logic                   is_box, is_corner, has_result, out_free, fire;
   logic [PLANE_COUNT-1:0] and_next, or_next;

   always_comb begin
      is_box     = (item.command == CMD_BOX);
      is_corner  = (item.command == CMD_CORNER);
      has_result = is_box || (is_corner && item.last);
      out_free   = !rsp_valid_ff || !rsp_stall;
      item_ready = !has_result || out_free;
      fire       = item_valid && item_ready;

      and_next = and_ff & item.near_mask;
      or_next  = or_ff | item.near_mask;

      and_in = and_ff;
      or_in  = or_ff;
      if (fire && is_corner) begin
         if (item.last) begin
            and_in = ALL_PLANES;
            or_in  = '0;
         end else begin
            and_in = and_next;
            or_in  = or_next;
         end
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      touches_in   = touches_ff;
      fully_in     = fully_ff;
      mask_in      = mask_ff;
      if (fire && has_result) begin
         rsp_valid_in = 1'b1;
         if (is_box) begin
            kind_in    = KIND_BOX;
            touches_in = (item.near_mask == '0);
            fully_in   = (item.far_mask == '0);
            mask_in    = mask_to_out(item.near_mask);
         end else begin
            kind_in    = KIND_CORNER;
            touches_in = (and_next == '0);
            fully_in   = (or_next == '0);
            mask_in    = mask_to_out(and_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         and_ff       <= ALL_PLANES;
         or_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         and_ff       <= and_in;
         or_ff        <= or_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      touches_ff <= touches_in;
      fully_ff   <= fully_in;
      mask_ff    <= mask_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_test_kind       = kind_ff;
   assign rsp_touches_frustum = touches_ff;
   assign rsp_fully_inside    = fully_ff;
   assign rsp_outside_mask    = mask_ff;

   // A finished corner set leaves the accumulators at their starting values.
   a_acc_restart: assert property (@(posedge clock) disable iff (reset)
      fire && is_corner && item.last |=> (and_ff == ALL_PLANES) && (or_ff == '0))
      else $error("corner accumulators not restarted after last corner");

   // Every corner inside all planes implies the set touches the frustum.
   a_corner_fully: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (kind_ff == KIND_CORNER) && fully_ff |-> touches_ff)
      else $error("corner result fully inside but not touching");

   // The row is held back only by a stalled, occupied output register.
   a_hold_cause: assert property (@(posedge clock) disable iff (reset)
      item_valid && !item_ready |-> rsp_valid_ff && rsp_stall)
      else $error("retire stage held without a stalled result");

endmodule

### rtl/frustum_box_cull.sv
// ----------------------------------------------------------------------------
// frustum_box_cull
// Culls axis-aligned boxes and corner sets against stored frustum planes.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Carries
//   req_     in         req_valid/req_stall   load, box test or corner test
//   rsp_     out        rsp_valid/rsp_stall   kind, touches, fully, mask
//
// One transaction is accepted per cycle for as long as the row has room.
// On its way to rsp_valid a transaction passes a multiply, a pair-sum and
// a final-sum stage in each plane cell, and then the retire stage writes
// the output register.
// Reset clears all plane coefficients to zero, empties the pipeline and
// restarts the corner accumulators.
// A stall on rsp_ only holds the stages behind the waiting result; bubbles
// further up keep closing, so req_stall rises only when the row is full.
//
// Each plane lives in its own cell. A transaction walks the row of cells in
// order, and each cell adds its plane's outside bit to the nearest-corner
// and farthest-corner masks the transaction carries. Coefficient loads walk
// the same row and are captured by the cell they address as they enter it,
// so every test sees exactly the planes loaded before it. Loads to slots
// beyond the last plane match no cell and vanish. Command code 3 is
// accepted and dropped at the door.
//
// For a corner test the box maximum is replaced by the corner itself, so the
// nearest and farthest corners coincide and the near mask is the corner's
// outside code. The retire stage ANDs and ORs those codes together and
// reports on the last corner of a set.
// ----------------------------------------------------------------------------
module frustum_box_cull import fbc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [CMD_W-1:0]           req_command,
   input  logic [SLOT_W-1:0]          req_coef_slot,
   input  logic signed [FIELD_W-1:0]  req_coef_value,
   input  logic signed [FIELD_W-1:0]  req_lo_x,
   input  logic signed [FIELD_W-1:0]  req_lo_y,
   input  logic signed [FIELD_W-1:0]  req_lo_z,
   input  logic signed [FIELD_W-1:0]  req_hi_x,
   input  logic signed [FIELD_W-1:0]  req_hi_y,
   input  logic signed [FIELD_W-1:0]  req_hi_z,
   input  logic                       req_last_corner,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_test_kind,
   output logic                       rsp_touches_frustum,
   output logic                       rsp_fully_inside,
   output logic [OUT_MASK_W-1:0]      rsp_outside_mask
);

   // Links between cells: link 0 feeds the first cell, the last link feeds
   // the retire stage.
   item_type link_item  [PLANE_COUNT+1];
   logic     link_valid [PLANE_COUNT+1];
   logic     link_ready [PLANE_COUNT+1];

   // Build the entering transaction. Corner tests use the corner as both
   // box limits, and the masks start empty.
   always_comb begin
      link_item[0].command   = req_command;
      link_item[0].slot      = req_coef_slot;
      link_item[0].value     = req_coef_value;
      link_item[0].lo_x      = req_lo_x;
      link_item[0].lo_y      = req_lo_y;
      link_item[0].lo_z      = req_lo_z;
      link_item[0].last      = req_last_corner;
      link_item[0].near_mask = '0;
      link_item[0].far_mask  = '0;
      if (req_command == CMD_CORNER) begin
         link_item[0].hi_x = req_lo_x;
         link_item[0].hi_y = req_lo_y;
         link_item[0].hi_z = req_lo_z;
      end else begin
         link_item[0].hi_x = req_hi_x;
         link_item[0].hi_y = req_hi_y;
         link_item[0].hi_z = req_hi_z;
      end
      link_valid[0] = req_valid && (req_command != CMD_UNUSED);
   end

   assign req_stall = !link_ready[0];

   for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_cell
      fbc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .plane_idx (PLANE_SEL_W'(p)),
         .up_valid  (link_valid[p]),
         .up_item   (link_item[p]),
         .up_ready  (link_ready[p]),
         .dn_valid  (link_valid[p+1]),
         .dn_item   (link_item[p+1]),
         .dn_ready  (link_ready[p+1])
      );
   end

   fbc_retire u_retire (
      .clock               (clock),
      .reset               (reset),
      .item_valid          (link_valid[PLANE_COUNT]),
      .item                (link_item[PLANE_COUNT]),
      .item_ready          (link_ready[PLANE_COUNT]),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_test_kind       (rsp_test_kind),
      .rsp_touches_frustum (rsp_touches_frustum),
      .rsp_fully_inside    (rsp_fully_inside),
      .rsp_outside_mask    (rsp_outside_mask)
   );

endmodule
